// ----- rtl/sia_pkg.sv -----
// shared opcodes, status codes and front-to-back word type for the stack alu
package sia_pkg;

   localparam int OpW = 5;
   localparam int ImmW = 32;
   localparam int WordW = 64;
   localparam int StatW = 2;

   localparam logic [OpW-1:0] OP_PUSH = 5'd0;
   localparam logic [OpW-1:0] OP_NULL = 5'd1;
   localparam logic [OpW-1:0] OP_TRUE = 5'd2;
   localparam logic [OpW-1:0] OP_FALSE = 5'd3;
   localparam logic [OpW-1:0] OP_ADD = 5'd4;
   localparam logic [OpW-1:0] OP_SUB = 5'd5;
   localparam logic [OpW-1:0] OP_MUL = 5'd6;
   localparam logic [OpW-1:0] OP_DIV = 5'd7;
   localparam logic [OpW-1:0] OP_MOD = 5'd8;
   localparam logic [OpW-1:0] OP_NEG = 5'd9;
   localparam logic [OpW-1:0] OP_NOT = 5'd10;
   localparam logic [OpW-1:0] OP_EQ = 5'd11;
   localparam logic [OpW-1:0] OP_NE = 5'd12;
   localparam logic [OpW-1:0] OP_LT = 5'd13;
   localparam logic [OpW-1:0] OP_LE = 5'd14;
   localparam logic [OpW-1:0] OP_GT = 5'd15;
   localparam logic [OpW-1:0] OP_GE = 5'd16;
   localparam logic [OpW-1:0] OP_AND = 5'd17;
   localparam logic [OpW-1:0] OP_OR = 5'd18;
   localparam logic [OpW-1:0] OP_POP = 5'd19;
   localparam logic [OpW-1:0] OP_DUP = 5'd20;

   localparam logic [StatW-1:0] ST_OK = 2'd0;
   localparam logic [StatW-1:0] ST_UNDER = 2'd1;
   localparam logic [StatW-1:0] ST_OVER = 2'd2;
   localparam logic [StatW-1:0] ST_DIVZ = 2'd3;

   // operand class decided in the front end
   localparam logic [2:0] CL_NOP = 3'd0;
   localparam logic [2:0] CL_PUSH = 3'd1;
   localparam logic [2:0] CL_BIN = 3'd2;
   localparam logic [2:0] CL_UNARY = 3'd3;
   localparam logic [2:0] CL_POP = 3'd4;
   localparam logic [2:0] CL_DUP = 3'd5;

   typedef struct packed {
      logic [OpW-1:0] op;
      logic [2:0] cls;
      logic [WordW-1:0] value;
   } instr_type;

endpackage

// ----- rtl/sia_front.sv -----
// front end: classifies an instruction and holds it in a two-word queue
module sia_front (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [sia_pkg::OpW-1:0] op,
   input logic signed [sia_pkg::ImmW-1:0] imm,
   output logic q_valid,
   input logic q_take,
   output sia_pkg::instr_type q_word
);
   import sia_pkg::*;

   instr_type slot_ff [2];
   instr_type slot_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic acc;

   assign full = (cnt_ff == 2'd2);
   assign acc = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = slot_ff[rd_ff];

   // classify and form the pushed constant
   always_comb begin
      slot_in.op = op;
      slot_in.value = '0;
      if (op == OP_PUSH) begin
         slot_in.value = {{(WordW-ImmW){imm[ImmW-1]}}, imm};
      end else if (op == OP_TRUE) begin
         slot_in.value = 64'd1;
      end
      if (op <= OP_FALSE) slot_in.cls = CL_PUSH;
      else if ((op >= OP_ADD && op <= OP_MOD) || (op >= OP_EQ && op <= OP_OR))
         slot_in.cls = CL_BIN;
      else if (op == OP_NEG || op == OP_NOT) slot_in.cls = CL_UNARY;
      else if (op == OP_POP) slot_in.cls = CL_POP;
      else if (op == OP_DUP) slot_in.cls = CL_DUP;
      else slot_in.cls = CL_NOP;
   end

   // queue pointers
   always_comb begin
      rd_in = rd_ff ^ (q_take && q_valid);
      wr_in = wr_ff ^ acc;
      cnt_in = cnt_ff + {1'b0, acc} - {1'b0, q_take && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) slot_ff[wr_ff] <= slot_in;
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (full && !(q_take && q_valid)) |=> full) else $error("full dropped without take");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (rd_ff == wr_ff)) else $error("pointers differ when empty");
`endif
endmodule

// ----- rtl/sia_divider.sv -----
// radix-2 restoring divider on magnitudes, one quotient bit per cycle
module sia_divider (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [sia_pkg::WordW-1:0] dividend,
   input logic [sia_pkg::WordW-1:0] divisor,
   output logic done,
   output logic [sia_pkg::WordW-1:0] quot,
   output logic [sia_pkg::WordW-1:0] rem
);
   import sia_pkg::*;

   logic [WordW-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [WordW:0] trial, shifted;

   assign done = done_ff;
   assign quot = q_ff;
   assign rem = r_ff;

   // one shift-subtract step
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {r_ff, q_ff[WordW-1]};
      trial = shifted - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WordW]) begin
            r_in = trial[WordW-1:0];
            q_in = {q_ff[WordW-2:0], 1'b1};
         end else begin
            r_in = shifted[WordW-1:0];
            q_in = {q_ff[WordW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

`ifndef SYNTHESIS
   a_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("start while busy");
   a_end: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == 7'd63 && !start) |=> done_ff) else $error("no done");
`endif
endmodule

// ----- rtl/sia_back.sv -----
// back end: stack memory, alu sequencer and result register
module sia_back #(
   parameter int STACK_DEPTH = 64
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   output logic q_take,
   input sia_pkg::instr_type q_word,
   output logic empty,
   input logic pop,
   output logic signed [sia_pkg::WordW-1:0] top_value,
   output logic [6:0] depth,
   output logic [sia_pkg::StatW-1:0] status
);
   import sia_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD = 3'd1;
   localparam logic [2:0] S_EXE = 3'd2;
   localparam logic [2:0] S_MUL = 3'd3;
   localparam logic [2:0] S_DIV = 3'd4;
   localparam logic [2:0] S_WB = 3'd5;
   localparam logic [2:0] S_TOP = 3'd6;

   logic [WordW-1:0] mem [STACK_DEPTH];
   logic [2:0] st_ff, st_in;
   logic [PW-1:0] sp_ff, sp_in;
   instr_type cur_ff;
   logic [WordW-1:0] a_ff, b_ff, res_ff, res_in, top_ff, rdata_ff, wdata;
   logic [AW-1:0] raddr, waddr;
   logic re, we;
   logic [StatW-1:0] stat_ff, stat_in;
   logic out_v_ff;
   logic [WordW-1:0] out_top_ff;
   logic [PW-1:0] out_sp_ff;
   logic [StatW-1:0] out_st_ff;
   logic [WordW-1:0] p00_ff;
   logic [31:0] p01_ff, p10_ff;
   logic div_start, div_done;
   logic [WordW-1:0] div_q, div_r, mag_a, mag_b;
   logic slt_ab, slt_ba;
   logic finish;
   logic [PW-1:0] fin_sp;
   logic [WordW-1:0] fin_top;

   assign empty = !out_v_ff;
   assign top_value = out_top_ff;
   assign depth = 7'(out_sp_ff);
   assign status = out_st_ff;
   assign mag_a = a_ff[WordW-1] ? -a_ff : a_ff;
   assign mag_b = b_ff[WordW-1] ? -b_ff : b_ff;
   assign slt_ab = $signed(a_ff) < $signed(b_ff);
   assign slt_ba = $signed(b_ff) < $signed(a_ff);
   assign q_take = (st_ff == S_IDLE) && q_valid && !(out_v_ff && !pop);

   sia_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(mag_a), .divisor(mag_b),
      .done(div_done), .quot(div_q), .rem(div_r)
   );

   // memory read and write
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      sp_in = sp_ff;
      stat_in = stat_ff;
      res_in = res_ff;
      re = 1'b0;
      raddr = '0;
      we = 1'b0;
      waddr = '0;
      wdata = res_ff;
      div_start = 1'b0;
      finish = 1'b0;
      fin_sp = sp_ff;
      fin_top = top_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (q_take) begin
               stat_in = ST_OK;
               priority case (q_word.cls)
                  CL_PUSH: begin
                     if (sp_ff == PW'(STACK_DEPTH)) begin
                        stat_in = ST_OVER;
                        st_in = S_WB;
                     end else begin
                        we = 1'b1;
                        waddr = AW'(sp_ff);
                        wdata = q_word.value;
                        sp_in = sp_ff + PW'(1);
                        res_in = q_word.value;
                        st_in = S_WB;
                     end
                  end
                  CL_BIN: begin
                     if (sp_ff < PW'(2)) begin
                        stat_in = ST_UNDER;
                        st_in = S_WB;
                     end else begin
                        re = 1'b1;
                        raddr = AW'(sp_ff - PW'(2));
                        st_in = S_RD;
                     end
                  end
                  CL_UNARY, CL_POP, CL_DUP: begin
                     if (sp_ff == '0) begin
                        stat_in = ST_UNDER;
                        st_in = S_WB;
                     end else if (q_word.cls == CL_POP) begin
                        sp_in = sp_ff - PW'(1);
                        st_in = (sp_ff == PW'(1)) ? S_WB : S_TOP;
                        if (sp_ff != PW'(1)) begin
                           re = 1'b1;
                           raddr = AW'(sp_ff - PW'(2));
                        end
                     end else if (q_word.cls == CL_DUP) begin
                        if (sp_ff == PW'(STACK_DEPTH)) begin
                           stat_in = ST_OVER;
                        end else begin
                           we = 1'b1;
                           waddr = AW'(sp_ff);
                           wdata = top_ff;
                           sp_in = sp_ff + PW'(1);
                        end
                        res_in = top_ff;
                        st_in = S_WB;
                     end else begin
                        st_in = S_EXE;
                     end
                  end
                  default: st_in = S_WB;
               endcase
            end
         end
         S_RD: st_in = S_EXE;
         S_EXE: begin
            st_in = S_WB;
            priority case (cur_ff.op)
               OP_ADD: res_in = a_ff + b_ff;
               OP_SUB: res_in = a_ff - b_ff;
               OP_MUL: st_in = S_MUL;
               OP_DIV, OP_MOD: begin
                  if (b_ff == '0) stat_in = ST_DIVZ;
                  else begin
                     div_start = 1'b1;
                     st_in = S_DIV;
                  end
               end
               OP_NEG: res_in = -b_ff;
               OP_NOT: res_in = {63'd0, b_ff == '0};
               OP_EQ: res_in = {63'd0, a_ff == b_ff};
               OP_NE: res_in = {63'd0, a_ff != b_ff};
               OP_LT: res_in = {63'd0, slt_ab};
               OP_LE: res_in = {63'd0, !slt_ba};
               OP_GT: res_in = {63'd0, slt_ba};
               OP_GE: res_in = {63'd0, !slt_ab};
               OP_AND: res_in = a_ff & b_ff;
               OP_OR: res_in = a_ff | b_ff;
               default: res_in = res_ff;
            endcase
            if (stat_in == ST_OK && st_in == S_WB) begin
               we = 1'b1;
               waddr = (cur_ff.cls == CL_BIN) ? AW'(sp_ff - PW'(2)) : AW'(sp_ff - PW'(1));
               wdata = res_in;
               if (cur_ff.cls == CL_BIN) sp_in = sp_ff - PW'(1);
            end
         end
         S_MUL: begin
            res_in = p00_ff + {p01_ff + p10_ff, 32'd0};
            we = 1'b1;
            waddr = AW'(sp_ff - PW'(2));
            wdata = res_in;
            sp_in = sp_ff - PW'(1);
            st_in = S_WB;
         end
         S_DIV: begin
            if (div_done) begin
               if (cur_ff.op == OP_DIV)
                  res_in = (a_ff[WordW-1] ^ b_ff[WordW-1]) ? -div_q : div_q;
               else
                  res_in = a_ff[WordW-1] ? -div_r : div_r;
               we = 1'b1;
               waddr = AW'(sp_ff - PW'(2));
               wdata = res_in;
               sp_in = sp_ff - PW'(1);
               st_in = S_WB;
            end
         end
         S_TOP: begin
            res_in = rdata_ff;
            st_in = S_WB;
         end
         S_WB: begin
            finish = 1'b1;
            st_in = S_IDLE;
            fin_sp = sp_ff;
            if (stat_ff != ST_OK || cur_ff.cls == CL_NOP) fin_top = top_ff;
            else if (sp_ff == '0) fin_top = '0;
            else fin_top = res_ff;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         sp_ff <= '0;
         top_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         sp_ff <= sp_in;
         if (finish) begin
            top_ff <= fin_top;
            out_v_ff <= 1'b1;
         end else if (pop && out_v_ff) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // operand and result payload
   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      res_ff <= res_in;
      if (q_take) begin
         cur_ff <= q_word;
         b_ff <= top_ff;
      end
      if (st_ff == S_RD) a_ff <= rdata_ff;
      p00_ff <= WordW'(a_ff[31:0] * b_ff[31:0]);
      p01_ff <= a_ff[31:0] * b_ff[63:32];
      p10_ff <= a_ff[63:32] * b_ff[31:0];
      if (finish) begin
         out_top_ff <= fin_top;
         out_sp_ff <= fin_sp;
         out_st_ff <= stat_ff;
      end
   end

`ifndef SYNTHESIS
   a_sp: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |=> st_ff != S_IDLE) else $error("sequencer did not start");
   a_ovw: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !pop) |=> out_v_ff) else $error("result lost");
   a_we: assert property (@(posedge clock) disable iff (reset)
      we |-> sp_ff != PW'(STACK_DEPTH) || st_ff != S_IDLE) else $error("write past top");
`endif
endmodule

// ----- rtl/stack_integer_alu.sv -----
// top level of the stack integer alu: front queue and back sequencer
//
//  channel   handshake      payload
//  req       push / full    req_op, req_imm
//  rsp       pop / empty    rsp_top_value, rsp_depth, rsp_status
//
// sequencer path with an idle back end: push, constant, dup, unknown codes and pop of
// the last word go to S_WB; other pop via S_TOP; unary via S_EXE; binary via S_RD,
// S_EXE, with S_MUL for mul (split 32-bit partial products) and S_DIV for div/mod.
// reset is synchronous and empties the stack, queue and result register.
// the back end takes the next word only once the result register is free or popped;
// the front queue holds up to two words meanwhile.
module stack_integer_alu #(
   parameter int STACK_DEPTH = 64
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [sia_pkg::OpW-1:0] req_op,
   input logic signed [sia_pkg::ImmW-1:0] req_imm,
   output logic empty,
   input logic pop,
   output logic signed [sia_pkg::WordW-1:0] rsp_top_value,
   output logic [6:0] rsp_depth,
   output logic [sia_pkg::StatW-1:0] rsp_status
);
   import sia_pkg::*;

   logic q_valid, q_take;
   instr_type q_word;

   sia_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .op(req_op), .imm(req_imm),
      .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
   );

   sia_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_word(q_word),
      .empty(empty), .pop(pop),
      .top_value(rsp_top_value), .depth(rsp_depth), .status(rsp_status)
   );
endmodule

// ----- sim/tb_stack_integer_alu.sv -----
// testbench for the stack integer alu: queued stimulus, stack predictor and result checker
module tb_stack_integer_alu;
   import sia_pkg::*;

   localparam int Depth = 64;
   localparam int MaxCycles = 400000;
   localparam logic [OpW-1:0] OpUnknownLo = 5'd21;
   localparam logic [OpW-1:0] OpUnknownHi = 5'd31;

   typedef struct {
      logic [OpW-1:0] op;
      logic [ImmW-1:0] imm;
   } pending_type;

   typedef struct {
      logic [WordW-1:0] top;
      logic [6:0] depth;
      logic [StatW-1:0] status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic [OpW-1:0] req_op = '0;
   logic signed [ImmW-1:0] req_imm = '0;
   logic full, empty;
   logic signed [WordW-1:0] rsp_top_value;
   logic [6:0] rsp_depth;
   logic [StatW-1:0] rsp_status;

   pending_type pending_instrs[$];
   outcome_type expected_outcomes[$];
   logic [WordW-1:0] model_words[Depth];
   int model_sp = 0;
   int mismatch_total = 0;
   int checked_count = 0;
   int cycle_count = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   bit hold_rsp = 1'b0;
   int gap_left = 0;
   int burst_left = 0;

   stack_integer_alu #(.STACK_DEPTH(Depth)) u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_op(req_op), .req_imm(req_imm), .empty(empty), .pop(pop),
      .rsp_top_value(rsp_top_value), .rsp_depth(rsp_depth), .rsp_status(rsp_status)
   );

   always #4 clock = ~clock;

   // signed division truncating toward zero, built on unsigned magnitudes
   function automatic logic [WordW-1:0] mag(input logic [WordW-1:0] a);
      return a[WordW-1] ? -a : a;
   endfunction

   // stack predictor: applies one instruction, returns the expected outcome
   function automatic outcome_type execute_instr(input pending_type it);
      outcome_type o;
      logic [WordW-1:0] a, b, r, q;
      logic [StatW-1:0] st;
      st = ST_OK;
      r = '0;
      case (it.op)
         OP_PUSH, OP_NULL, OP_TRUE, OP_FALSE: begin
            if (model_sp >= Depth) st = ST_OVER;
            else begin
               model_words[model_sp] = (it.op == OP_PUSH) ? {{32{it.imm[31]}}, it.imm} :
                                       (it.op == OP_TRUE) ? 64'd1 : 64'd0;
               model_sp++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT,
         OP_GE, OP_AND, OP_OR: begin
            if (model_sp < 2) st = ST_UNDER;
            else begin
               a = model_words[model_sp-2];
               b = model_words[model_sp-1];
               case (it.op)
                  OP_ADD: r = a + b;
                  OP_SUB: r = a - b;
                  OP_MUL: r = a * b;
                  OP_DIV: begin
                     q = (b == 0) ? '0 : mag(a) / mag(b);
                     r = (a[63] ^ b[63]) ? -q : q;
                  end
                  OP_MOD: begin
                     q = (b == 0) ? '0 : mag(a) % mag(b);
                     r = a[63] ? -q : q;
                  end
                  OP_EQ: r = 64'(a == b);
                  OP_NE: r = 64'(a != b);
                  OP_LT: r = 64'($signed(a) < $signed(b));
                  OP_LE: r = 64'($signed(a) <= $signed(b));
                  OP_GT: r = 64'($signed(a) > $signed(b));
                  OP_GE: r = 64'($signed(a) >= $signed(b));
                  OP_AND: r = a & b;
                  default: r = a | b;
               endcase
               if ((it.op == OP_DIV || it.op == OP_MOD) && b == 0) st = ST_DIVZ;
               else begin
                  model_sp--;
                  model_words[model_sp-1] = r;
               end
            end
         end
         OP_NEG, OP_NOT, OP_POP: begin
            if (model_sp < 1) st = ST_UNDER;
            else if (it.op == OP_POP) model_sp--;
            else begin
               a = model_words[model_sp-1];
               model_words[model_sp-1] = (it.op == OP_NEG) ? -a : 64'(a == 0);
            end
         end
         OP_DUP: begin
            if (model_sp < 1) st = ST_UNDER;
            else if (model_sp >= Depth) st = ST_OVER;
            else begin
               model_words[model_sp] = model_words[model_sp-1];
               model_sp++;
            end
         end
         default: ;
      endcase
      o.top = (model_sp > 0) ? model_words[model_sp-1] : '0;
      o.depth = 7'(model_sp);
      o.status = st;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                  input logic [WordW-1:0] want);
      $display("mismatch at word %0d: %s got %h expected %h", checked_count, what, got, want);
      mismatch_total++;
   endtask

   task automatic add_instr(input logic [OpW-1:0] op, input logic [ImmW-1:0] imm);
      pending_type it;
      it.op = op;
      it.imm = imm;
      pending_instrs.push_back(it);
   endtask

   // push a random value of mixed magnitude
   task automatic add_rand_push();
      case ($urandom_range(0, 4))
         0: add_instr(OP_PUSH, $urandom_range(0, 8) - 4);
         1: add_instr(OP_PUSH, 32'h8000_0000 | $urandom_range(0, 3));
         2: add_instr(OP_PUSH, 32'h7FFF_FFFF - $urandom_range(0, 3));
         default: add_instr(OP_PUSH, $urandom());
      endcase
   endtask

   // driver: bursts with random gaps, holding the offered word while full
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_outcomes.push_back(execute_instr(pending_type'{req_op, req_imm}));
            void'(pending_instrs.pop_front());
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_instrs.size() > 0) begin
            req_op <= pending_instrs[0].op;
            req_imm <= pending_instrs[0].imm;
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: random stalls, with a long hold-off window
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected word", rsp_top_value, '0);
            end else begin
               outcome_type e;
               e = expected_outcomes.pop_front();
               if (rsp_top_value !== e.top) report_mismatch("top_value", rsp_top_value, e.top);
               if (rsp_depth !== e.depth)
                  report_mismatch("depth", 64'(rsp_depth), 64'(e.depth));
               if (rsp_status !== e.status)
                  report_mismatch("status", 64'(rsp_status), 64'(e.status));
               status_seen[e.status]++;
            end
            checked_count++;
         end
         pop <= !hold_rsp && ((cycle_count % 97 < 60) || $urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MaxCycles) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // long receiver hold-off so the front queue fills and stalls the sender
   initial begin
      wait (checked_count > 300);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: underflows on empty stack, extremes, every op, division corners
      add_instr(OP_POP, '0);
      add_instr(OP_ADD, '0);
      add_instr(OP_NEG, '0);
      add_instr(OP_DUP, '0);
      add_instr(OP_PUSH, 32'h8000_0000);
      add_instr(OP_NOT, '0);
      add_instr(OP_PUSH, 32'h7FFF_FFFF);
      add_instr(OP_MUL, '0);
      add_instr(OP_NEG, '0);
      add_instr(OP_DUP, '0);
      add_instr(OP_FALSE, '0);
      add_instr(OP_DIV, '0);
      add_instr(OP_MOD, '0);
      add_instr(OP_NULL, '0);
      add_instr(OP_TRUE, '0);
      add_instr(OP_SUB, '0);
      add_instr(OpUnknownHi, 32'hFFFF_FFFF);
      add_instr(OpUnknownLo, '0);
      for (int k = OP_ADD; k <= OP_OR; k++) begin
         if (k == OP_NEG || k == OP_NOT) continue;
         add_instr(OP_PUSH, 32'hFFFF_FFFD);
         add_instr(OP_PUSH, 32'h0000_0002);
         add_instr(k[OpW-1:0], '0);
      end
      // minimum value over minus one, quotient and remainder
      add_instr(OP_PUSH, 32'h8000_0000);
      add_instr(OP_DUP, '0);
      add_instr(OP_MUL, '0);
      add_instr(OP_PUSH, 32'hFFFF_FFFE);
      add_instr(OP_MUL, '0);
      add_instr(OP_DUP, '0);
      add_instr(OP_PUSH, 32'hFFFF_FFFF);
      add_instr(OP_DIV, '0);
      add_instr(OP_POP, '0);
      add_instr(OP_PUSH, 32'hFFFF_FFFF);
      add_instr(OP_MOD, '0);
      add_instr(OP_POP, '0);
      // fill to overflow
      for (int k = 0; k < Depth + 2; k++) add_instr(OP_TRUE, '0);
      add_instr(OP_DUP, '0);
      for (int k = 0; k < Depth + 2; k++) add_instr(OP_POP, '0);

      while (pending_instrs.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      // random: mostly well-formed programs, some noise
      n = 0;
      while (n < 800) begin
         if (n == 400) begin
            while (pending_instrs.size() != 0 || expected_outcomes.size() != 0)
               @(posedge clock);
         end
         case ($urandom_range(0, 9))
            0, 1, 2: add_rand_push();
            3: add_instr(OpW'($urandom_range(OP_NULL, OP_FALSE)), $urandom());
            4: add_instr(OpW'($urandom_range(OP_ADD, OP_MUL)), $urandom());
            5: add_instr(OpW'($urandom_range(OP_DIV, OP_MOD)), $urandom());
            6: add_instr(OpW'($urandom_range(OP_EQ, OP_OR)), $urandom());
            7: add_instr(OpW'($urandom_range(OP_NEG, OP_NOT)), $urandom());
            8: add_instr(($urandom_range(0, 1) != 0) ? OP_DUP : OP_POP, $urandom());
            default: add_instr(OpW'($urandom_range(0, 31)), $urandom());
         endcase
         n++;
         if (pending_instrs.size() > 40) @(posedge clock);
      end
      while (pending_instrs.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("checked %0d result words over directed corners and random programs",
               checked_count);
      $display("ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
               status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
               status_seen[ST_DIVZ]);
      if (mismatch_total == 0 && expected_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
